// File: rtl/hrbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbd_pkg
// Shared types and constants of the heart rate beat detector.
// ----------------------------------------------------------------------------
package hrbd_pkg;

  localparam int OpW      = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int AlphaW   = 16;
  localparam int OffW     = 6;
  localparam int LimW     = 8;
  localparam int NumerW   = 16;
  localparam int BaseW    = 12;
  localparam int PrevW    = 10;
  localparam int CountW   = 16;
  localparam int BpmW     = 12;
  localparam int AvgW     = 16;
  localparam int AvgIntW  = 8;

  // shared multiplier: unsigned weight times signed difference
  localparam int MulAW = AlphaW + 1;
  localparam int MulBW = 18;
  localparam int ProdW = MulAW + MulBW;
  localparam int FracW = 16;
  localparam int AdjW  = ProdW - FracW;
  localparam int SumW  = AdjW + 1;

  // restoring divider for (2n + t) / (2t)
  localparam int DivW     = NumerW + 2;
  localparam int RemW     = CountW + 1;
  localparam int DivSteps = DivW;
  localparam int StepW    = 5;

  localparam logic [BaseW-1:0]  BaseMax  = 12'd4095;
  localparam logic [BpmW-1:0]   BpmLimit = 12'd3000;
  localparam logic [CountW-1:0] CountMax = 16'hFFFF;

  localparam logic [AlphaW-1:0] SignalAlphaRst = 16'd3277;
  localparam logic [OffW-1:0]   OffsetRst      = 6'd5;
  localparam logic [AlphaW-1:0] RateAlphaRst   = 16'd6554;
  localparam logic [LimW-1:0]   FloorRst       = 8'd30;
  localparam logic [LimW-1:0]   CeilingRst     = 8'd150;
  localparam logic [NumerW-1:0] NumerRst       = 16'd3000;

  typedef enum logic [OpW-1:0] {
    OP_SAMPLE    = 2'd0,
    OP_TICK      = 2'd1,
    OP_CLR_AVG   = 2'd2,
    OP_CLR_TOTAL = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SIGNAL_ALPHA = 3'd0,
    REG_BASE_OFFSET  = 3'd1,
    REG_RATE_ALPHA   = 3'd2,
    REG_BPM_FLOOR    = 3'd3,
    REG_BPM_CEILING  = 3'd4,
    REG_RATE_NUMER   = 3'd5
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MISC,
    ST_BASE_MUL,
    ST_BASE_UPD,
    ST_DIV,
    ST_DIV_END,
    ST_AVG_MUL,
    ST_AVG_UPD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic misc;
    logic base_mul;
    logic base_upd;
    logic div_step;
    logic div_end;
    logic avg_mul;
    logic avg_upd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic pair_end;
    logic avg_mix;
  } sts_t;

endpackage

// File: rtl/hrbd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbd_in_if
// Request channel: operation code and ADC sample.
// ----------------------------------------------------------------------------
interface hrbd_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                         valid;
  logic                         ready;
  logic [hrbd_pkg::OpW-1:0]     op;
  logic [SAMPLE_BITS-1:0]       sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

// File: rtl/hrbd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbd_out_if
// Result channel: beat flags, rates, baseline and beat total.
// ----------------------------------------------------------------------------
interface hrbd_out_if;
  logic                           valid;
  logic                           ready;
  logic                           beat;
  logic                           rate_valid;
  logic [hrbd_pkg::BpmW-1:0]      instant_bpm;
  logic [hrbd_pkg::AvgIntW-1:0]   average_bpm;
  logic [hrbd_pkg::BaseW-1:0]     baseline;
  logic [hrbd_pkg::CountW-1:0]    total_beats;

  modport source (output valid, output beat, output rate_valid, output instant_bpm,
                  output average_bpm, output baseline, output total_beats, input ready);
  modport sink   (input valid, input beat, input rate_valid, input instant_bpm,
                  input average_bpm, input baseline, input total_beats, output ready);
endinterface

// File: rtl/hrbd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbd_ctrl
// Sequencer: walks each request through its misc, baseline, divide and average steps.
// ----------------------------------------------------------------------------
module hrbd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hrbd_pkg::op_e       op_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  hrbd_pkg::sts_t      sts_i,
  output hrbd_pkg::cmd_t      cmd_o
);

  hrbd_pkg::state_e                state_q, state_d;
  logic [hrbd_pkg::StepW-1:0]      step_q, step_d;
  logic                            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hrbd_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    case (state_q)
      hrbd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = (op_i == hrbd_pkg::OP_SAMPLE) ? hrbd_pkg::ST_BASE_MUL
                                                  : hrbd_pkg::ST_MISC;
        end
      end
      hrbd_pkg::ST_MISC: begin
        cmd_o.misc = 1'b1;
        state_d    = hrbd_pkg::ST_OUT;
      end
      hrbd_pkg::ST_BASE_MUL: begin
        cmd_o.base_mul = 1'b1;
        state_d        = hrbd_pkg::ST_BASE_UPD;
      end
      hrbd_pkg::ST_BASE_UPD: begin
        cmd_o.base_upd = 1'b1;
        step_d         = '0;
        // second beat of a pair goes on to the rate divide
        state_d = sts_i.pair_end ? hrbd_pkg::ST_DIV : hrbd_pkg::ST_OUT;
      end
      hrbd_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == hrbd_pkg::StepW'(hrbd_pkg::DivSteps - 1)) begin
          state_d = hrbd_pkg::ST_DIV_END;
        end
      end
      hrbd_pkg::ST_DIV_END: begin
        cmd_o.div_end = 1'b1;
        state_d = sts_i.avg_mix ? hrbd_pkg::ST_AVG_MUL : hrbd_pkg::ST_OUT;
      end
      hrbd_pkg::ST_AVG_MUL: begin
        cmd_o.avg_mul = 1'b1;
        state_d       = hrbd_pkg::ST_AVG_UPD;
      end
      hrbd_pkg::ST_AVG_UPD: begin
        cmd_o.avg_upd = 1'b1;
        state_d       = hrbd_pkg::ST_OUT;
      end
      hrbd_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = hrbd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hrbd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/hrbd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbd_datapath
// Registers, shared multiplier, restoring divider and result register.
// ----------------------------------------------------------------------------
module hrbd_datapath #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hrbd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [hrbd_pkg::CfgDataW-1:0]     cfg_data_i,
  input  hrbd_pkg::op_e                     op_i,
  input  logic [SAMPLE_BITS-1:0]            sample_i,
  input  hrbd_pkg::cmd_t                    cmd_i,
  output hrbd_pkg::sts_t                    sts_o,
  output logic                              beat_o,
  output logic                              rate_valid_o,
  output logic [hrbd_pkg::BpmW-1:0]         instant_bpm_o,
  output logic [hrbd_pkg::AvgIntW-1:0]      average_bpm_o,
  output logic [hrbd_pkg::BaseW-1:0]        baseline_o,
  output logic [hrbd_pkg::CountW-1:0]       total_beats_o
);

  localparam int CmpW = (SAMPLE_BITS > hrbd_pkg::BaseW) ? SAMPLE_BITS : hrbd_pkg::BaseW;

  // configuration
  logic [hrbd_pkg::AlphaW-1:0] sig_alpha_q, rate_alpha_q;
  logic [hrbd_pkg::OffW-1:0]   offset_q;
  logic [hrbd_pkg::LimW-1:0]   floor_q, ceil_q;
  logic [hrbd_pkg::NumerW-1:0] numer_q;

  // detector state
  logic [hrbd_pkg::BaseW-1:0]  base_q;
  logic [hrbd_pkg::PrevW-1:0]  prev_q;
  logic                        parity_q, running_q, seeded_q;
  logic [hrbd_pkg::CountW-1:0] ticks_q, total_q;
  logic [hrbd_pkg::BpmW-1:0]   bpm_q;
  logic [hrbd_pkg::AvgW-1:0]   avg_q;
  logic                        beat_q, rvalid_q;

  // working registers
  hrbd_pkg::op_e                    op_q;
  logic [SAMPLE_BITS-1:0]           samp_q;
  logic [hrbd_pkg::ProdW-1:0]       prod_q;
  logic [hrbd_pkg::RemW-1:0]        rem_q;
  logic [hrbd_pkg::DivW-1:0]        quo_q;
  logic [hrbd_pkg::RemW-1:0]        dvsr_q;

  logic                             out_beat_q, out_rvalid_q;
  logic [hrbd_pkg::BpmW-1:0]        out_bpm_q;
  logic [hrbd_pkg::AvgIntW-1:0]     out_avg_q;
  logic [hrbd_pkg::BaseW-1:0]       out_base_q;
  logic [hrbd_pkg::CountW-1:0]      out_total_q;

  logic signed [hrbd_pkg::MulAW-1:0] mul_a;
  logic signed [hrbd_pkg::MulBW-1:0] mul_b, diff_base, diff_avg;
  logic signed [hrbd_pkg::ProdW-1:0] mul_p;
  logic [hrbd_pkg::SumW-1:0]         prod_adj, base_sum, avg_sum;
  logic [hrbd_pkg::BaseW-1:0]        base_new;
  logic                              beat_hit;
  logic [hrbd_pkg::DivW-1:0]         dividend, trial, trial_sub;
  logic                              fits;
  logic [hrbd_pkg::BpmW-1:0]         bpm_new;
  logic                              in_range;

  // ---------------- shared multiplier ----------------
  assign diff_base = $signed({{(hrbd_pkg::MulBW-SAMPLE_BITS){1'b0}}, samp_q})
                   - $signed({{(hrbd_pkg::MulBW-hrbd_pkg::BaseW){1'b0}}, base_q});
  assign diff_avg  = $signed({2'b00, bpm_q[hrbd_pkg::AvgIntW-1:0], 8'h00})
                   - $signed({{(hrbd_pkg::MulBW-hrbd_pkg::AvgW){1'b0}}, avg_q});
  assign mul_a = cmd_i.avg_mul ? $signed({1'b0, rate_alpha_q}) : $signed({1'b0, sig_alpha_q});
  assign mul_b = cmd_i.avg_mul ? diff_avg : diff_base;
  assign mul_p = mul_a * mul_b;

  // weighted step is floor(alpha * diff / 2^16), sign extended
  assign prod_adj = {prod_q[hrbd_pkg::ProdW-1], prod_q[hrbd_pkg::ProdW-1:hrbd_pkg::FracW]};

  // ---------------- baseline and crossing ----------------
  assign base_sum = {{(hrbd_pkg::SumW-hrbd_pkg::BaseW){1'b0}}, base_q} + prod_adj
                  + {{(hrbd_pkg::SumW-hrbd_pkg::OffW){1'b0}}, offset_q};
  assign base_new = (base_sum > {{(hrbd_pkg::SumW-hrbd_pkg::BaseW){1'b0}}, hrbd_pkg::BaseMax})
                  ? hrbd_pkg::BaseMax : base_sum[hrbd_pkg::BaseW-1:0];
  assign beat_hit = (CmpW'(samp_q) > CmpW'(base_new))
                 && ({{(hrbd_pkg::BaseW-hrbd_pkg::PrevW){1'b0}}, prev_q} < base_new);

  // ---------------- divider ----------------
  assign dividend  = {1'b0, numer_q, 1'b0} + {2'b00, ticks_q};
  assign trial     = {rem_q, quo_q[hrbd_pkg::DivW-1]};
  assign fits      = trial >= {1'b0, dvsr_q};
  assign trial_sub = trial - {1'b0, dvsr_q};
  assign bpm_new   = (quo_q > {{(hrbd_pkg::DivW-hrbd_pkg::BpmW){1'b0}}, hrbd_pkg::BpmLimit})
                   ? hrbd_pkg::BpmLimit : quo_q[hrbd_pkg::BpmW-1:0];
  assign in_range  = (bpm_new > {{(hrbd_pkg::BpmW-hrbd_pkg::LimW){1'b0}}, floor_q})
                  && (bpm_new < {{(hrbd_pkg::BpmW-hrbd_pkg::LimW){1'b0}}, ceil_q});

  assign avg_sum = {{(hrbd_pkg::SumW-hrbd_pkg::AvgW){1'b0}}, avg_q} + prod_adj;

  assign sts_o.pair_end = beat_hit && parity_q;
  assign sts_o.avg_mix  = in_range && seeded_q;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_alpha_q  <= hrbd_pkg::SignalAlphaRst;
      offset_q     <= hrbd_pkg::OffsetRst;
      rate_alpha_q <= hrbd_pkg::RateAlphaRst;
      floor_q      <= hrbd_pkg::FloorRst;
      ceil_q       <= hrbd_pkg::CeilingRst;
      numer_q      <= hrbd_pkg::NumerRst;
    end else if (cfg_we_i) begin
      case (hrbd_pkg::reg_e'(cfg_idx_i))
        hrbd_pkg::REG_SIGNAL_ALPHA: sig_alpha_q  <= cfg_data_i;
        hrbd_pkg::REG_BASE_OFFSET:  offset_q     <= cfg_data_i[hrbd_pkg::OffW-1:0];
        hrbd_pkg::REG_RATE_ALPHA:   rate_alpha_q <= cfg_data_i;
        hrbd_pkg::REG_BPM_FLOOR:    floor_q      <= cfg_data_i[hrbd_pkg::LimW-1:0];
        hrbd_pkg::REG_BPM_CEILING:  ceil_q       <= cfg_data_i[hrbd_pkg::LimW-1:0];
        hrbd_pkg::REG_RATE_NUMER:   numer_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- detector state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      prev_q    <= '0;
      parity_q  <= 1'b0;
      running_q <= 1'b0;
      ticks_q   <= '0;
      bpm_q     <= '0;
      avg_q     <= '0;
      seeded_q  <= 1'b0;
      total_q   <= '0;
      beat_q    <= 1'b0;
      rvalid_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        beat_q   <= 1'b0;
        rvalid_q <= 1'b0;
      end
      if (cmd_i.misc) begin
        case (op_q)
          hrbd_pkg::OP_TICK: begin
            if (running_q && (ticks_q != hrbd_pkg::CountMax)) begin
              ticks_q <= ticks_q + 1'b1;
            end
          end
          hrbd_pkg::OP_CLR_AVG:   avg_q   <= '0;
          hrbd_pkg::OP_CLR_TOTAL: total_q <= '0;
          default: ;
        endcase
      end
      if (cmd_i.base_upd) begin
        base_q <= base_new;
        prev_q <= hrbd_pkg::PrevW'(samp_q);
        if (beat_hit) begin
          beat_q <= 1'b1;
          if (total_q != hrbd_pkg::CountMax) begin
            total_q <= total_q + 1'b1;
          end
          if (!parity_q) begin
            parity_q  <= 1'b1;
            running_q <= 1'b1;
          end else begin
            parity_q  <= 1'b0;
            running_q <= 1'b0;
            ticks_q   <= '0;
          end
        end
      end
      if (cmd_i.div_end) begin
        bpm_q    <= bpm_new;
        rvalid_q <= 1'b1;
        // first in-range rate seeds the average
        if (in_range && !seeded_q) begin
          avg_q    <= {bpm_new[hrbd_pkg::AvgIntW-1:0], 8'h00};
          seeded_q <= 1'b1;
        end
      end
      if (cmd_i.avg_upd) begin
        avg_q <= avg_sum[hrbd_pkg::AvgW-1:0];
      end
    end
  end

  // ---------------- working and result registers ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      samp_q <= sample_i;
    end
    if (cmd_i.base_mul || cmd_i.avg_mul) begin
      prod_q <= mul_p;
    end
    if (cmd_i.base_upd) begin
      // zero ticks divides by zero: quotient is all ones and saturates
      rem_q  <= '0;
      quo_q  <= dividend;
      dvsr_q <= {ticks_q, 1'b0};
    end
    if (cmd_i.div_step) begin
      rem_q <= fits ? trial_sub[hrbd_pkg::RemW-1:0] : trial[hrbd_pkg::RemW-1:0];
      quo_q <= {quo_q[hrbd_pkg::DivW-2:0], fits};
    end
    if (cmd_i.out_load) begin
      out_beat_q   <= beat_q;
      out_rvalid_q <= rvalid_q;
      out_bpm_q    <= bpm_q;
      out_avg_q    <= avg_q[hrbd_pkg::AvgW-1:hrbd_pkg::AvgW-hrbd_pkg::AvgIntW];
      out_base_q   <= base_q;
      out_total_q  <= total_q;
    end
  end

  assign beat_o        = out_beat_q;
  assign rate_valid_o  = out_rvalid_q;
  assign instant_bpm_o = out_bpm_q;
  assign average_bpm_o = out_avg_q;
  assign baseline_o    = out_base_q;
  assign total_beats_o = out_total_q;

endmodule

// File: rtl/heart_rate_beat_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heart_rate_beat_detector_unit
// Beat detector on an EWMA baseline with interval-based bpm and averaging.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  req_i   | in  | valid / ready | op, sample
//  res_o   | out | valid / ready | beat, rate_valid, instant_bpm, average_bpm,
//          |     |               | baseline, total_beats
//  cfg     | in  | cfg_we_i      | cfg_idx_i, cfg_data_i
//
// tick and clear requests go through the misc step to the result register, a
// sample through baseline multiply and update, and the second beat of a pair
// also the 18-step restoring divider and the shared multiplier of the average.
// the result register lets the next request in while a result waits; a
// stalled result holds the sequencer before its next result load.
// reset is asynchronous and leaves no clearing pass.
module heart_rate_beat_detector_unit #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hrbd_in_if.sink                       req_i,
  hrbd_out_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [hrbd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hrbd_pkg::CfgDataW-1:0] cfg_data_i
);

  hrbd_pkg::cmd_t cmd;
  hrbd_pkg::sts_t sts;
  hrbd_pkg::op_e  req_op;

  assign req_op = hrbd_pkg::op_e'(req_i.op);

  hrbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .op_i        (req_op),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hrbd_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .op_i          (req_op),
    .sample_i      (req_i.sample),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .beat_o        (res_o.beat),
    .rate_valid_o  (res_o.rate_valid),
    .instant_bpm_o (res_o.instant_bpm),
    .average_bpm_o (res_o.average_bpm),
    .baseline_o    (res_o.baseline),
    .total_beats_o (res_o.total_beats)
  );

endmodule

// File: rtl/hrbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbd_checker
// Port-level checks of the beat detector, bound to the top level.
// ----------------------------------------------------------------------------
module hrbd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          beat_i,
  input logic                          rate_valid_i,
  input logic [hrbd_pkg::BpmW-1:0]     instant_bpm_i,
  input logic [hrbd_pkg::AvgIntW-1:0]  average_bpm_i,
  input logic [hrbd_pkg::BaseW-1:0]    baseline_i,
  input logic [hrbd_pkg::CountW-1:0]   total_beats_i
);

  // one request at a time in the sequencer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while previous one still in work");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(beat_i)
      && $stable(rate_valid_i) && $stable(instant_bpm_i) && $stable(average_bpm_i)
      && $stable(baseline_i) && $stable(total_beats_i))
    else $error("stalled result changed");

  // a new rate only comes from a beat
  a_rate_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && rate_valid_i |-> beat_i)
    else $error("rate reported without beat");

  a_bpm_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> instant_bpm_i <= hrbd_pkg::BpmLimit)
    else $error("instant bpm above limit");

endmodule

bind heart_rate_beat_detector_unit hrbd_checker u_hrbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .beat_i        (res_o.beat),
  .rate_valid_i  (res_o.rate_valid),
  .instant_bpm_i (res_o.instant_bpm),
  .average_bpm_i (res_o.average_bpm),
  .baseline_i    (res_o.baseline),
  .total_beats_i (res_o.total_beats)
);
